// ----- rtl/cfc_pkg.sv -----
// shared constants for the camera frame capture block
// register indexes, capture modes and internal counter widths; no dependencies
`default_nettype none
package cfc_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd5;

    localparam logic [1:0] MODE_RAW_FAST = 2'd0;
    localparam logic [1:0] MODE_RAW_SLOW = 2'd1;
    localparam logic [1:0] MODE_BIN      = 2'd2;
    localparam logic [1:0] MODE_INVALID  = 2'd3;

    localparam logic [1:0] KIND_STORE_A = 2'd0;
    localparam logic [1:0] KIND_STORE_B = 2'd1;

    localparam int unsigned PIX_W  = 8;
    localparam int unsigned SUM_W  = 9;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned CNT_W  = 12;
    localparam int unsigned ROW_W  = 13;

endpackage
`default_nettype wire

// ----- rtl/camera_frame_capture_crop_bin_top.sv -----
// camera capture with crop and 2x2 bayer binning
// one beat per cycle in while the output is not stalled, result registered in the cycle after the beat that causes it
// binning sums go through the line store ram (one read, one write port)
// reset clears control and configuration; the line store needs no clearing:
// the first binned row merges with zero and later reads hit entries
// written earlier in the same capture
`default_nettype none
module camera_frame_capture_crop_bin_top #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire [15:0]                         i_s_tdata,   // vsync, hsync, pixel[7:0]
    input  wire [0:0]                          i_s_tuser,   // command
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [39:0]                        o_m_tdata,   // write_address, write_data
    output logic                               o_m_tlast,   // last_write
    output logic [0:0]                         o_m_tuser,   // error
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [cfc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [cfc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import cfc_pkg::*;

    localparam int unsigned STORE_DEPTH = 2 * MAX_WIDTH;
    localparam int unsigned STORE_AW = $clog2(STORE_DEPTH);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_VHIGH     = 3'd1;
    localparam logic [2:0] PH_VLOW      = 3'd2;
    localparam logic [2:0] PH_SKIPLINES = 3'd3;
    localparam logic [2:0] PH_LINEWAIT  = 3'd4;
    localparam logic [2:0] PH_PIXSKIP   = 3'd5;
    localparam logic [2:0] PH_DATA      = 3'd6;

    // configuration
    logic [1:0]        r_mode;
    logic [9:0]        r_x_offset, r_y_offset;
    logic [10:0]       r_x_width, r_y_height;
    logic [ADDR_W-1:0] r_base;

    // latched at start
    logic [1:0]        r_cur_mode;
    logic [10:0]       r_cur_stride, r_cur_w, r_cur_yskip;
    logic [ADDR_W-1:0] r_cur_base;
    logic [CNT_W-1:0]  r_cur_xskip, r_cur_data;
    logic [ROW_W-1:0]  r_cur_lines;

    logic [2:0]        r_phase, n_phase;
    logic [10:0]       r_line_count, n_line_count;
    logic [CNT_W-1:0]  r_pixel_count, n_pixel_count;
    logic [ROW_W-1:0]  r_row_count, n_row_count;
    logic              r_last_hsync, n_last_hsync;
    logic [PIX_W-1:0]  r_held0, r_held1;
    logic [ADDR_W-1:0] r_row_addr, n_row_addr;
    logic [1:0]        r_kind, n_kind;
    logic              r_row0, n_row0;

    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    logic [PIX_W-1:0]  r_out_data, n_out_data;
    logic              r_out_last, n_out_last, r_out_err, n_out_err, n_res;

    logic              w_acc, w_cmd, w_vs, w_hs, w_rise, w_start, w_bad, w_begin;
    logic [PIX_W-1:0]  w_px;

    // start-time values
    logic [10:0]       w_w, w_h, s_w, s_yskip;
    logic [CNT_W-1:0]  s_xskip, s_data;
    logic [ROW_W-1:0]  s_lines;
    logic [10:0]       w_hp1_half;

    // line start values
    logic [ROW_W-1:0]  w_rm1, w_orow;
    logic [1:0]        w_kind;
    logic [23:0]       w_prod;

    // data pixel path
    logic [1:0]        w_pos;
    logic [10:0]       w_e, w_kbase;
    logic [CNT_W-1:0]  w_idx, w_ridx, w_pc1;
    logic [SUM_W-1:0]  w_sum, w_mem, w_rdata;
    logic [9:0]        w_merge;
    logic              w_bin, w_re, w_we;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_acc = i_s_tvalid && o_s_tready;
    assign w_cmd = i_s_tuser[0];
    assign w_vs  = i_s_tdata[0];
    assign w_hs  = i_s_tdata[1];
    assign w_px  = i_s_tdata[9:2];
    assign w_rise  = w_hs && !r_last_hsync;
    assign w_start = w_acc && w_cmd;
    assign w_bad   = r_mode == MODE_INVALID;

    always_comb begin
        w_w = ({2'b00, r_x_width} > 13'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : r_x_width;
        w_h = ({2'b00, r_y_height} > 13'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : r_y_height;
        w_hp1_half = 11'((12'(w_h) + 12'd1) >> 1);
        if (r_mode == MODE_BIN) begin
            s_w     = {w_w[10:1], 1'b0};
            s_xskip = {11'(r_x_offset) + 11'd1, 1'b0};
            s_yskip = {r_y_offset, 1'b0};
            s_data  = {s_w, 1'b0};
            s_lines = {w_hp1_half[10:0], 2'b00} + 13'd1;
        end else begin
            s_w     = w_w;
            s_xskip = {2'b00, r_x_offset[9:1], 1'b0} + 12'd2;
            s_yskip = {1'b0, r_y_offset[9:1], 1'b0};
            s_data  = {1'b0, w_w};
            s_lines = {2'b00, w_h};
        end
    end

    // output row and store kind for the line about to begin
    always_comb begin
        w_rm1 = r_row_count - 13'd1;
        w_kind = 2'd2;
        w_orow = r_row_count;
        if (r_cur_mode == MODE_BIN) begin
            if (r_row_count == '0) begin
                w_orow = '0;
            end else begin
                w_kind = w_rm1[1:0];
                w_orow = ((w_kind == 2'd2) ? 13'd1 : 13'd2) + {w_rm1[12:2], 1'b0};
            end
        end
        w_prod = 24'(w_orow) * 24'(r_cur_stride);
    end

    always_comb begin
        w_bin   = r_cur_mode == MODE_BIN;
        w_pos   = r_pixel_count[1:0];
        w_e     = {r_pixel_count[11:2], r_pixel_count[0]};
        w_kbase = r_kind[0] ? r_cur_w : 11'd0;
        w_idx   = 12'(w_kbase) + 12'(w_e);
        w_ridx  = 12'(w_kbase) + 12'({r_pixel_count[11:2], w_pos == 2'd2});
        w_sum   = 9'(w_pos[0] ? r_held1 : r_held0) + 9'(w_px);
        w_mem   = r_row0 ? '0 : w_rdata;
        w_merge = 10'(w_mem) + 10'(w_sum);
        w_pc1   = r_pixel_count + 12'd1;
        w_re = w_acc && !w_cmd && r_phase == PH_DATA && w_bin
            && (w_pos == 2'd1 || w_pos == 2'd2);
        w_we = w_acc && !w_cmd && r_phase == PH_DATA && w_bin && w_pos[1]
            && (r_kind == KIND_STORE_A || r_kind == KIND_STORE_B);
    end

    cfc_ram #(
        .WIDTH(SUM_W),
        .DEPTH(STORE_DEPTH)
    ) u_line_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(STORE_AW'(w_idx)),
        .i_wdata(w_sum),
        .i_re   (w_re),
        .i_raddr(STORE_AW'(w_ridx)),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_phase = r_phase;
        n_line_count = r_line_count;
        n_pixel_count = r_pixel_count;
        n_row_count = r_row_count;
        n_last_hsync = r_last_hsync;
        n_row_addr = r_row_addr;
        n_kind = r_kind;
        n_row0 = r_row0;
        n_res = 1'b0;
        n_out_addr = '0;
        n_out_data = '0;
        n_out_last = 1'b0;
        n_out_err = 1'b0;
        w_begin = 1'b0;
        if (w_acc && w_cmd) begin
            if (w_bad) begin
                n_phase = PH_IDLE;
                n_res = 1'b1;
                n_out_err = 1'b1;
            end else begin
                n_line_count = '0;
                n_pixel_count = '0;
                n_row_count = '0;
                n_phase = (s_lines == '0) ? PH_IDLE : PH_VHIGH;
            end
        end else if (w_acc) begin
            n_last_hsync = w_hs;
            unique case (r_phase)
                PH_VHIGH: begin
                    if (w_vs) n_phase = PH_VLOW;
                end
                PH_VLOW: begin
                    if (!w_vs) begin
                        n_phase = PH_SKIPLINES;
                        n_line_count = '0;
                    end
                end
                PH_SKIPLINES: begin
                    if (w_rise) begin
                        if (r_line_count < r_cur_yskip) n_line_count = r_line_count + 11'd1;
                        else w_begin = 1'b1;
                    end
                end
                PH_LINEWAIT: begin
                    if (w_rise) w_begin = 1'b1;
                end
                PH_PIXSKIP: begin
                    n_pixel_count = w_pc1;
                    if (w_pc1 >= r_cur_xskip) begin
                        n_phase = PH_DATA;
                        n_pixel_count = '0;
                        if (r_cur_data == '0) begin
                            n_row_count = r_row_count + 13'd1;
                            n_phase = (r_row_count + 13'd1 >= r_cur_lines) ? PH_IDLE
                                                                            : PH_LINEWAIT;
                        end
                    end
                end
                PH_DATA: begin
                    if (w_bin) begin
                        if (w_pos[1] && !(r_kind == KIND_STORE_A || r_kind == KIND_STORE_B)) begin
                            n_res = 1'b1;
                            n_out_addr = r_row_addr + 32'(w_e);
                            n_out_data = w_merge[9:2];
                            n_out_last = (r_row_count + 13'd1 == r_cur_lines)
                                && (12'(w_e) + 12'd1 == 12'(r_cur_w));
                        end
                    end else begin
                        n_res = 1'b1;
                        n_out_addr = r_row_addr + 32'(r_pixel_count);
                        n_out_data = w_px;
                        n_out_last = (r_row_count + 13'd1 == r_cur_lines)
                            && (w_pc1 == 12'(r_cur_w));
                    end
                    n_pixel_count = w_pc1;
                    if (w_pc1 >= r_cur_data) begin
                        n_pixel_count = '0;
                        n_row_count = r_row_count + 13'd1;
                        n_phase = (r_row_count + 13'd1 >= r_cur_lines) ? PH_IDLE : PH_LINEWAIT;
                    end
                end
                default: begin
                end
            endcase
            if (w_begin) begin
                n_pixel_count = 12'd1;
                n_phase = PH_PIXSKIP;
                n_row_addr = r_cur_base + 32'(w_prod);
                n_kind = w_kind;
                n_row0 = w_bin && r_row_count == '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RAW_FAST;
            r_x_offset <= '0;
            r_y_offset <= '0;
            r_x_width <= 11'd320;
            r_y_height <= 11'd200;
            r_base <= '0;
            r_cur_mode <= '0;
            r_cur_stride <= '0;
            r_cur_w <= '0;
            r_cur_yskip <= '0;
            r_cur_base <= '0;
            r_cur_xskip <= '0;
            r_cur_data <= '0;
            r_cur_lines <= '0;
            r_phase <= PH_IDLE;
            r_line_count <= '0;
            r_pixel_count <= '0;
            r_row_count <= '0;
            r_last_hsync <= 1'b0;
            r_kind <= '0;
            r_row0 <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MODE:     r_mode <= i_cfg_data[1:0];
                    REG_X_OFFSET: r_x_offset <= i_cfg_data[9:0];
                    REG_Y_OFFSET: r_y_offset <= i_cfg_data[9:0];
                    REG_X_WIDTH:  r_x_width <= i_cfg_data[10:0];
                    REG_Y_HEIGHT: r_y_height <= i_cfg_data[10:0];
                    REG_BASE:     r_base <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_start && !w_bad) begin
                r_cur_mode <= r_mode;
                r_cur_stride <= r_x_width;
                r_cur_w <= s_w;
                r_cur_yskip <= s_yskip;
                r_cur_base <= r_base;
                r_cur_xskip <= s_xskip;
                r_cur_data <= s_data;
                r_cur_lines <= s_lines;
            end
            r_phase <= n_phase;
            r_line_count <= n_line_count;
            r_pixel_count <= n_pixel_count;
            r_row_count <= n_row_count;
            r_last_hsync <= n_last_hsync;
            r_kind <= n_kind;
            r_row0 <= n_row0;
            if (w_acc && n_res) r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_addr <= n_row_addr;
        if (w_acc && !w_cmd && r_phase == PH_DATA && w_bin) begin
            if (w_pos == 2'd0) r_held0 <= w_px;
            if (w_pos == 2'd1) r_held1 <= w_px;
        end
        if (w_acc && n_res) begin
            r_out_addr <= n_out_addr;
            r_out_data <= n_out_data;
            r_out_last <= n_out_last;
            r_out_err <= n_out_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_data, r_out_addr};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_err;

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err |-> !r_out_last && r_out_addr == '0 && r_out_data == '0)
        else $error("error beat carries payload");

    a_bad_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start && w_bad |=> r_phase == PH_IDLE && r_out_valid && r_out_err)
        else $error("refused start did not go idle with an error beat");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_out_valid && !i_m_tready)
        else $error("input stalled without a waiting result");

    a_store_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> !(r_out_valid && !$past(r_out_valid && !i_m_tready) && !r_out_err
            && $past(r_phase == PH_DATA)))
        else $error("store line produced a result");
endmodule
`default_nettype wire

// ----- rtl/cfc_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module cfc_ram #(
    parameter int unsigned WIDTH = 9,
    parameter int unsigned DEPTH = 2048
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire
